[hw/rtl/i2cms_pkg.sv]
`timescale 1ns / 1ps

package i2cms_pkg;

  localparam int unsigned ActionW   = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned TickW     = 10;
  localparam int unsigned BitIdxW   = 4;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 10;

  localparam logic [ByteW-1:0]   SetupReset   = 8'd4;
  localparam logic [ByteW-1:0]   BitPhaseReset = 8'd2;
  localparam logic [TickW-1:0]   AckTimeoutReset = 10'd250;
  localparam logic [BitIdxW-1:0] BitsPerByte  = 4'd8;

  typedef enum logic [ActionW-1:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_WRITE = 3'd3,
    ACT_WAIT  = 3'd4,
    ACT_READ  = 3'd5
  } action_t;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_SETUP       = 2'd0,
    CFG_BIT_PHASE   = 2'd1,
    CFG_ACK_TIMEOUT = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ST1  = 4'd1,
    PH_ST2  = 4'd2,
    PH_SP1  = 4'd3,
    PH_SP2  = 4'd4,
    PH_WRA  = 4'd5,
    PH_WRB  = 4'd6,
    PH_WRC  = 4'd7,
    PH_WA1  = 4'd8,
    PH_WA2  = 4'd9,
    PH_WAP  = 4'd10,
    PH_RDA  = 4'd11,
    PH_RDB  = 4'd12,
    PH_AK1  = 4'd13,
    PH_AK2  = 4'd14
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] setup_ticks;
    logic [ByteW-1:0] bit_phase_ticks;
    logic [TickW-1:0] ack_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [TickW-1:0]   tick_count;
    logic [BitIdxW-1:0] bit_index;
    logic [ByteW-1:0]   shift_byte;
    logic               send_ack;
    logic               scl;
    logic               sda;
    logic               drive;
    logic               ack_missing;
    logic [ByteW-1:0]   rx_hold;
  } seq_state_t;

  localparam seq_state_t SeqStateReset = '{
    phase:       PH_IDLE,
    tick_count:  '0,
    bit_index:   '0,
    shift_byte:  '0,
    send_ack:    1'b0,
    scl:         1'b1,
    sda:         1'b1,
    drive:       1'b0,
    ack_missing: 1'b0,
    rx_hold:     '0
  };

  // a programmed count of zero still holds the phase for one tick
  function automatic logic [ByteW-1:0] span(input logic [ByteW-1:0] v);
    span = (v == '0) ? 8'd1 : v;
  endfunction

endpackage

[hw/rtl/i2cms_cmd_if.sv]
`timescale 1ns / 1ps

interface i2cms_cmd_if;
  import i2cms_pkg::*;

  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [ByteW-1:0]   write_byte;
  logic               ack_after_read;
  logic               sda_sample;

  modport source (
    output valid, action, write_byte, ack_after_read, sda_sample,
    input  ready
  );
  modport sink (
    input  valid, action, write_byte, ack_after_read, sda_sample,
    output ready
  );
endinterface

[hw/rtl/i2cms_res_if.sv]
`timescale 1ns / 1ps

interface i2cms_res_if;
  import i2cms_pkg::*;

  logic             valid;
  logic             ready;
  logic             scl_level;
  logic             sda_level;
  logic             sda_drive;
  logic             busy_res;
  logic             done_res;
  logic [ByteW-1:0] read_byte;
  logic             ack_missing;

  modport source (
    output valid, scl_level, sda_level, sda_drive, busy_res, done_res, read_byte,
           ack_missing,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, sda_drive, busy_res, done_res, read_byte,
           ack_missing,
    output ready
  );
endinterface

[hw/rtl/i2cms_cfg_if.sv]
`timescale 1ns / 1ps

interface i2cms_cfg_if;
  import i2cms_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/i2cms_cfg_regs.sv]
`timescale 1ns / 1ps

module i2cms_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  i2cms_cfg_if.sink       cfg,
  output i2cms_pkg::cfg_t regs
);
  import i2cms_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.setup_ticks       <= SetupReset;
      regs.bit_phase_ticks   <= BitPhaseReset;
      regs.ack_timeout_ticks <= AckTimeoutReset;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SETUP:       regs.setup_ticks       <= cfg.data[ByteW-1:0];
        CFG_BIT_PHASE:   regs.bit_phase_ticks   <= cfg.data[ByteW-1:0];
        CFG_ACK_TIMEOUT: regs.ack_timeout_ticks <= cfg.data[TickW-1:0];
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/i2cms_step.sv]
`timescale 1ns / 1ps

module i2cms_step (
  input  i2cms_pkg::seq_state_t         cur,
  input  i2cms_pkg::cfg_t               cfg,
  input  logic [i2cms_pkg::ActionW-1:0] action,
  input  logic [i2cms_pkg::ByteW-1:0]   write_byte,
  input  logic                          ack_after_read,
  input  logic                          sda_sample,
  output i2cms_pkg::seq_state_t         nxt,
  output logic                          done
);
  import i2cms_pkg::*;

  logic [ByteW-1:0]   limit;
  logic [TickW-1:0]   tick_inc;
  logic [BitIdxW-1:0] bit_inc;

  always_comb begin
    nxt      = cur;
    done     = 1'b0;
    limit    = 8'd1;
    tick_inc = '0;
    bit_inc  = '0;

    // launch a command on the tick it arrives
    if (cur.phase == PH_IDLE) begin
      nxt.tick_count = '0;
      case (action)
        ACT_START: begin
          nxt.scl   = 1'b1;
          nxt.sda   = 1'b1;
          nxt.drive = 1'b1;
          nxt.phase = PH_ST1;
        end
        ACT_STOP: begin
          nxt.scl   = 1'b0;
          nxt.sda   = 1'b0;
          nxt.drive = 1'b1;
          nxt.phase = PH_SP1;
        end
        ACT_WRITE: begin
          nxt.drive      = 1'b1;
          nxt.scl        = 1'b0;
          nxt.shift_byte = write_byte;
          nxt.bit_index  = '0;
          nxt.sda        = write_byte[ByteW-1];
          nxt.phase      = PH_WRA;
        end
        ACT_WAIT: begin
          nxt.drive = 1'b0;
          nxt.sda   = 1'b1;
          nxt.phase = PH_WA1;
        end
        ACT_READ: begin
          nxt.drive      = 1'b0;
          nxt.scl        = 1'b0;
          nxt.shift_byte = '0;
          nxt.bit_index  = '0;
          nxt.send_ack   = ack_after_read;
          nxt.phase      = PH_RDA;
        end
        default: ;
      endcase
    end

    if (nxt.phase == PH_WAP) begin
      if (!sda_sample) begin
        nxt.scl         = 1'b0;
        nxt.ack_missing = 1'b0;
        done            = 1'b1;
        nxt.phase       = PH_IDLE;
      end else if (nxt.tick_count >= cfg.ack_timeout_ticks) begin
        // no ack in time: release the bus with a stop
        nxt.ack_missing = 1'b1;
        nxt.scl         = 1'b0;
        nxt.sda         = 1'b0;
        nxt.drive       = 1'b1;
        nxt.phase       = PH_SP1;
        nxt.tick_count  = '0;
      end else begin
        nxt.tick_count = nxt.tick_count + 10'd1;
      end
    end else if (nxt.phase != PH_IDLE) begin
      case (nxt.phase) inside
        PH_ST1, PH_ST2, PH_SP1, PH_SP2: limit = span(cfg.setup_ticks);
        PH_WA1, PH_WA2, PH_RDB:         limit = 8'd1;
        default:                        limit = span(cfg.bit_phase_ticks);
      endcase
      tick_inc       = nxt.tick_count + 10'd1;
      bit_inc        = nxt.bit_index + 4'd1;
      nxt.tick_count = tick_inc;
      if (tick_inc >= {2'b00, limit}) begin
        nxt.tick_count = '0;
        case (nxt.phase)
          PH_ST1: begin
            nxt.sda   = 1'b0;
            nxt.phase = PH_ST2;
          end
          PH_ST2: begin
            nxt.scl   = 1'b0;
            done      = 1'b1;
            nxt.phase = PH_IDLE;
          end
          PH_SP1: begin
            nxt.scl   = 1'b1;
            nxt.sda   = 1'b1;
            nxt.phase = PH_SP2;
          end
          PH_SP2: begin
            done      = 1'b1;
            nxt.phase = PH_IDLE;
          end
          PH_WRA: begin
            nxt.scl   = 1'b1;
            nxt.phase = PH_WRB;
          end
          PH_WRB: begin
            nxt.scl   = 1'b0;
            nxt.phase = PH_WRC;
          end
          PH_WRC: begin
            nxt.bit_index = bit_inc;
            if (bit_inc >= BitsPerByte) begin
              done      = 1'b1;
              nxt.phase = PH_IDLE;
            end else begin
              nxt.shift_byte = {nxt.shift_byte[ByteW-2:0], 1'b0};
              nxt.sda        = nxt.shift_byte[ByteW-1];
              nxt.phase      = PH_WRA;
            end
          end
          PH_WA1: begin
            nxt.scl   = 1'b1;
            nxt.phase = PH_WA2;
          end
          PH_WA2: nxt.phase = PH_WAP;
          PH_RDA: begin
            // sample SDA as SCL rises
            nxt.scl        = 1'b1;
            nxt.shift_byte = {nxt.shift_byte[ByteW-2:0], sda_sample};
            nxt.phase      = PH_RDB;
          end
          PH_RDB: begin
            nxt.bit_index = bit_inc;
            nxt.scl       = 1'b0;
            if (bit_inc >= BitsPerByte) begin
              nxt.rx_hold = nxt.shift_byte;
              nxt.drive   = 1'b1;
              nxt.sda     = !nxt.send_ack;
              nxt.phase   = PH_AK1;
            end else begin
              nxt.phase = PH_RDA;
            end
          end
          PH_AK1: begin
            nxt.scl   = 1'b1;
            nxt.phase = PH_AK2;
          end
          PH_AK2: begin
            nxt.scl   = 1'b0;
            done      = 1'b1;
            nxt.phase = PH_IDLE;
          end
          default: nxt.phase = PH_IDLE;
        endcase
      end
    end
  end

endmodule

[hw/rtl/i2c_master_bit_sequencer_top.sv]
`timescale 1ns / 1ps

// I2C master pin sequencer, stepped by one request per bus tick.
// cmd: each request is one tick from the prescaler, carrying an action,
//   the byte to write, the ACK/NACK choice for reads and the sampled SDA.
//   An action is taken only when the sequencer is idle; otherwise it is
//   ignored and the tick just advances the running sequence.
// res: one result per request with the SCL level, SDA level and drive
//   enable, busy, a done pulse, the last read byte and the ack timeout flag.
// cfg: writes setup, bit phase and ack timeout tick counts; always ready.
//   Write it only while no sequence is running.
// Each result is registered and appears the cycle after its request is accepted.
// Throughput: one request per cycle while cmd.ready is high; the sequencer
//   state and the result register update together in the accepting cycle.
// cmd.ready stays high while the result register is empty or being taken,
//   so a stalled receiver holds the result and stalls cmd behind it.
// Reset leaves the bus idle (SCL and SDA high, SDA released), config at its
//   defaults, and the result register empty.
module i2c_master_bit_sequencer_top (
  input logic       clk,
  input logic       rst,
  i2cms_cmd_if.sink cmd,
  i2cms_res_if.source res,
  i2cms_cfg_if.sink cfg
);
  import i2cms_pkg::*;

  cfg_t       regs;
  seq_state_t state;
  seq_state_t state_next;
  logic       done;
  logic       accept;

  i2cms_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  i2cms_step u_step (
    .cur            (state),
    .cfg            (regs),
    .action         (cmd.action),
    .write_byte     (cmd.write_byte),
    .ack_after_read (cmd.ack_after_read),
    .sda_sample     (cmd.sda_sample),
    .nxt            (state_next),
    .done           (done)
  );

  assign cmd.ready = !res.valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SeqStateReset;
      res.valid <= 1'b0;
    end else if (accept) begin
      state     <= state_next;
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // result payload: load on every accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      res.scl_level   <= state_next.scl;
      res.sda_level   <= state_next.sda;
      res.sda_drive   <= state_next.drive;
      res.busy_res    <= (state_next.phase != PH_IDLE);
      res.done_res    <= done;
      res.read_byte   <= state_next.rx_hold;
      res.ack_missing <= state_next.ack_missing;
    end
  end

endmodule

[tb/i2cms_checker.sv]
`timescale 1ns / 1ps

module i2cms_checker
  import i2cms_pkg::*;
(
  input  logic clk,
  input  logic rst,
  i2cms_cmd_if cmd,
  i2cms_res_if res,
  i2cms_cfg_if cfg,
  output int   fail_count,
  output int   pending,
  output logic seq_busy
);

  typedef struct packed {
    logic             scl;
    logic             sda;
    logic             drive;
    logic             busy;
    logic             done;
    logic [ByteW-1:0] rx;
    logic             ack_miss;
  } pins_t;

  typedef struct packed {
    phase_t             phase;
    logic [TickW-1:0]   ticks;
    logic [BitIdxW-1:0] bit_no;
    logic [ByteW-1:0]   shreg;
    logic               ack_out;
    logic               scl;
    logic               sda;
    logic               drive;
    logic               ack_miss;
    logic [ByteW-1:0]   rx;
  } bus_t;

  logic [ByteW-1:0] setup_len;
  logic [ByteW-1:0] bit_len;
  logic [TickW-1:0] ack_limit;
  bus_t             bus;
  pins_t            pins_due[$];
  int               errors = 0;

  function automatic void enter_stop();
    bus.scl   = 1'b0;
    bus.sda   = 1'b0;
    bus.drive = 1'b1;
    bus.phase = PH_SP1;
    bus.ticks = '0;
  endfunction

  // advance the bus by one tick and return the pins as they stand after it
  function automatic pins_t tick_bus(input logic [ActionW-1:0] act,
                                     input logic [ByteW-1:0] wb,
                                     input logic ack_in,
                                     input logic sda_in);
    pins_t            o;
    logic             done;
    logic [TickW-1:0] span_len;
    done = 1'b0;
    span_len = TickW'(1);
    if (bus.phase == PH_IDLE) begin
      bus.ticks = '0;
      case (act)
        ACT_START: begin
          bus.scl   = 1'b1;
          bus.sda   = 1'b1;
          bus.drive = 1'b1;
          bus.phase = PH_ST1;
        end
        ACT_STOP: enter_stop();
        ACT_WRITE: begin
          bus.drive  = 1'b1;
          bus.scl    = 1'b0;
          bus.shreg  = wb;
          bus.bit_no = '0;
          bus.sda    = wb[ByteW-1];
          bus.phase  = PH_WRA;
        end
        ACT_WAIT: begin
          bus.drive = 1'b0;
          bus.sda   = 1'b1;
          bus.phase = PH_WA1;
        end
        ACT_READ: begin
          bus.drive   = 1'b0;
          bus.scl     = 1'b0;
          bus.shreg   = '0;
          bus.bit_no  = '0;
          bus.ack_out = ack_in;
          bus.phase   = PH_RDA;
        end
        default: ;
      endcase
    end

    if (bus.phase == PH_WAP) begin
      if (!sda_in) begin
        bus.scl      = 1'b0;
        bus.ack_miss = 1'b0;
        done         = 1'b1;
        bus.phase    = PH_IDLE;
      end else if (bus.ticks >= ack_limit) begin
        bus.ack_miss = 1'b1;
        enter_stop();
      end else begin
        bus.ticks = bus.ticks + 1'b1;
      end
    end else if (bus.phase != PH_IDLE) begin
      case (bus.phase)
        PH_ST1, PH_ST2, PH_SP1, PH_SP2: span_len = TickW'(setup_len);
        PH_WA1, PH_WA2, PH_RDB:         span_len = TickW'(1);
        default:                        span_len = TickW'(bit_len);
      endcase
      // a zero count still holds the phase for one tick
      if (span_len == '0) span_len = TickW'(1);
      bus.ticks = bus.ticks + 1'b1;
      if (bus.ticks >= span_len) begin
        bus.ticks = '0;
        case (bus.phase)
          PH_ST1: begin
            bus.sda   = 1'b0;
            bus.phase = PH_ST2;
          end
          PH_ST2: begin
            bus.scl   = 1'b0;
            done      = 1'b1;
            bus.phase = PH_IDLE;
          end
          PH_SP1: begin
            bus.scl   = 1'b1;
            bus.sda   = 1'b1;
            bus.phase = PH_SP2;
          end
          PH_SP2: begin
            done      = 1'b1;
            bus.phase = PH_IDLE;
          end
          PH_WRA: begin
            bus.scl   = 1'b1;
            bus.phase = PH_WRB;
          end
          PH_WRB: begin
            bus.scl   = 1'b0;
            bus.phase = PH_WRC;
          end
          PH_WRC: begin
            bus.bit_no = bus.bit_no + 1'b1;
            if (bus.bit_no >= BitsPerByte) begin
              done      = 1'b1;
              bus.phase = PH_IDLE;
            end else begin
              bus.shreg = bus.shreg << 1;
              bus.sda   = bus.shreg[ByteW-1];
              bus.phase = PH_WRA;
            end
          end
          PH_WA1: begin
            bus.scl   = 1'b1;
            bus.phase = PH_WA2;
          end
          PH_WA2: bus.phase = PH_WAP;
          PH_RDA: begin
            // sample SDA as SCL rises
            bus.scl   = 1'b1;
            bus.shreg = {bus.shreg[ByteW-2:0], sda_in};
            bus.phase = PH_RDB;
          end
          PH_RDB: begin
            bus.bit_no = bus.bit_no + 1'b1;
            bus.scl    = 1'b0;
            if (bus.bit_no >= BitsPerByte) begin
              bus.rx    = bus.shreg;
              bus.drive = 1'b1;
              bus.sda   = !bus.ack_out;
              bus.phase = PH_AK1;
            end else begin
              bus.phase = PH_RDA;
            end
          end
          PH_AK1: begin
            bus.scl   = 1'b1;
            bus.phase = PH_AK2;
          end
          PH_AK2: begin
            bus.scl   = 1'b0;
            done      = 1'b1;
            bus.phase = PH_IDLE;
          end
          default: bus.phase = PH_IDLE;
        endcase
      end
    end

    o = '{bus.scl, bus.sda, bus.drive, bus.phase != PH_IDLE, done, bus.rx, bus.ack_miss};
    return o;
  endfunction

  function automatic void cmp(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    pins_t want;
    pins_t got;
    if (rst) begin
      setup_len    = SetupReset;
      bit_len      = BitPhaseReset;
      ack_limit    = AckTimeoutReset;
      bus.phase    = PH_IDLE;
      bus.ticks    = '0;
      bus.bit_no   = '0;
      bus.shreg    = '0;
      bus.ack_out  = 1'b0;
      bus.scl      = 1'b1;
      bus.sda      = 1'b1;
      bus.drive    = 1'b0;
      bus.ack_miss = 1'b0;
      bus.rx       = '0;
      pins_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_SETUP:       setup_len = cfg.data[ByteW-1:0];
          CFG_BIT_PHASE:   bit_len = cfg.data[ByteW-1:0];
          CFG_ACK_TIMEOUT: ack_limit = cfg.data[TickW-1:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        pins_due.push_back(tick_bus(cmd.action, cmd.write_byte, cmd.ack_after_read,
                                    cmd.sda_sample));
      end
      if (res.valid && res.ready) begin
        got = '{res.scl_level, res.sda_level, res.sda_drive, res.busy_res, res.done_res,
                res.read_byte, res.ack_missing};
        if (pins_due.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          errors++;
        end else begin
          want = pins_due.pop_front();
          cmp("scl_level", want.scl, got.scl);
          cmp("sda_level", want.sda, got.sda);
          cmp("sda_drive", want.drive, got.drive);
          cmp("busy_res", want.busy, got.busy);
          cmp("done_res", want.done, got.done);
          cmp("read_byte", want.rx, got.rx);
          cmp("ack_missing", want.ack_miss, got.ack_miss);
        end
      end
    end
    pending    <= pins_due.size();
    seq_busy   <= (bus.phase != PH_IDLE);
    fail_count <= errors;
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import i2cms_pkg::*;

  localparam logic [ActionW-1:0]   ActUndefLo = 3'd6;
  localparam logic [ActionW-1:0]   ActUndefHi = 3'd7;
  localparam logic [CfgIndexW-1:0] CfgSpare   = 2'd3;
  localparam int                   QuietLimit = 1000;
  localparam int                   ItemTarget = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sink_ready = 1'b1;
  int   stall_left = 0;
  bit   steady = 1'b0;
  int   quiet_cycles = 0;
  int   issued = 0;
  int   ack_cfg = 250;
  int   fail_count;
  int   pending;
  logic seq_busy;

  i2cms_cmd_if cmd_if ();
  i2cms_res_if res_if ();
  i2cms_cfg_if cfg_if ();

  assign res_if.ready = sink_ready;

  i2c_master_bit_sequencer_top dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  i2cms_checker watch (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_if),
    .res        (res_if),
    .cfg        (cfg_if),
    .fail_count (fail_count),
    .pending    (pending),
    .seq_busy   (seq_busy)
  );

  always #5 clk = ~clk;

  // receiver: stall in random bursts, never once the run goes steady
  always @(posedge clk) begin
    if (rst || steady) begin
      sink_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= (stall_left == 1);
    end else if ($urandom_range(11) == 0) begin
      stall_left <= $urandom_range(15, 1);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("i2c_master_bit_sequencer_top: mismatch");
      $finish;
    end
  end

  task automatic send_tick(input logic [ActionW-1:0] act, input logic [ByteW-1:0] wb,
                           input logic ack, input logic sd);
    if (!steady && $urandom_range(9) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    cmd_if.valid          <= 1'b1;
    cmd_if.action         <= act;
    cmd_if.write_byte     <= wb;
    cmd_if.ack_after_read <= ack;
    cmd_if.sda_sample     <= sd;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    issued++;
  endtask

  // issue one command, then tick along until the sequence has finished
  task automatic run_cmd(input logic [ActionW-1:0] act, input logic [ByteW-1:0] wb,
                         input logic ack, input int hold);
    int                 k;
    logic [ActionW-1:0] noise;
    send_tick(act, wb, ack, (act == ACT_WAIT) ? 1'b1 : 1'($urandom));
    k = 0;
    do begin
      noise = ($urandom_range(5) == 0) ? ActionW'($urandom_range(7)) : ACT_NONE;
      send_tick(noise, ByteW'($urandom), 1'($urandom),
                (act == ACT_WAIT) ? (k < hold) : 1'($urandom));
      k++;
    end while (seq_busy);
  endtask

  // ticks of SDA held high before the slave acks; the timeout falls near ack_cfg + 2
  function automatic int ack_hold();
    case ($urandom_range(7))
      0, 1, 2: return $urandom_range(3);
      3, 4:    return $urandom_range(ack_cfg + 2);
      5, 6:    return ack_cfg + $urandom_range(4);
      default: return ack_cfg + 40;
    endcase
  endfunction

  // hold requests until every result is back and the sequencer is idle
  task automatic settle();
    while (seq_busy) send_tick(ACT_NONE, '0, 1'b0, 1'b1);
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    while (seq_busy) begin
      send_tick(ACT_NONE, '0, 1'b0, 1'b1);
      cmd_if.valid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
    end
  endtask

  task automatic put_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic write_regs(input logic [ByteW-1:0] su, input logic [ByteW-1:0] bp,
                            input logic [TickW-1:0] at, input bit spare);
    settle();
    repeat (2) @(posedge clk);
    put_reg(CFG_SETUP, {2'($urandom), su});
    put_reg(CFG_BIT_PHASE, {2'($urandom), bp});
    put_reg(CFG_ACK_TIMEOUT, at);
    if (spare) put_reg(CfgSpare, CfgDataW'($urandom));
    cfg_if.valid <= 1'b0;
    ack_cfg = at;
  endtask

  task automatic run_transfer();
    run_cmd(ACT_START, '0, 1'b0, 0);
    run_cmd(ACT_WRITE, ByteW'($urandom), 1'($urandom), 0);
    run_cmd(ACT_WAIT, '0, 1'b0, ack_hold());
    repeat ($urandom_range(3, 1)) begin
      if ($urandom_range(1) == 0) begin
        run_cmd(ACT_WRITE, ByteW'($urandom), 1'($urandom), 0);
        run_cmd(ACT_WAIT, '0, 1'b0, ack_hold());
      end else begin
        run_cmd(ACT_READ, ByteW'($urandom), 1'($urandom), 0);
      end
    end
    run_cmd(ACT_STOP, '0, 1'b0, 0);
  endtask

  initial begin
    logic [ByteW-1:0] su;
    logic [ByteW-1:0] bp;
    logic [TickW-1:0] at;
    int               base;
    int               quota;
    cmd_if.valid          <= 1'b0;
    cmd_if.action         <= ACT_NONE;
    cmd_if.write_byte     <= '0;
    cmd_if.ack_after_read <= 1'b0;
    cmd_if.sda_sample     <= 1'b1;
    cfg_if.valid          <= 1'b0;
    cfg_if.index          <= CFG_SETUP;
    cfg_if.data           <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset timing
    run_cmd(ACT_START, '0, 1'b0, 0);
    run_cmd(ACT_WRITE, 8'h00, 1'b0, 0);
    run_cmd(ACT_WAIT, '0, 1'b0, 0);
    run_cmd(ACT_WRITE, 8'hFF, 1'b1, 0);
    run_cmd(ACT_WAIT, '0, 1'b0, 260);
    run_cmd(ACT_READ, '0, 1'b1, 0);
    run_cmd(ACT_READ, '0, 1'b0, 0);
    run_cmd(ACT_STOP, '0, 1'b0, 0);
    run_cmd(ACT_NONE, 8'hFF, 1'b1, 0);
    run_cmd(ActUndefLo, 8'h55, 1'b1, 0);
    run_cmd(ActUndefHi, 8'hAA, 1'b0, 0);
    run_cmd(ACT_WRITE, 8'hA5, 1'b0, 0);

    // zero counts: one tick per phase, timeout on the first high poll
    write_regs(8'd0, 8'd0, 10'd0, 1'b1);
    run_cmd(ACT_START, '0, 1'b0, 0);
    run_cmd(ACT_WRITE, 8'h5A, 1'b0, 0);
    run_cmd(ACT_WAIT, '0, 1'b0, 3);
    run_cmd(ACT_WAIT, '0, 1'b0, 0);
    run_cmd(ACT_READ, '0, 1'b1, 0);
    run_cmd(ACT_STOP, '0, 1'b0, 0);

    // widest setup and ack timeout counts, kept to short sequences
    write_regs(8'd255, 8'd1, 10'd1023, 1'b0);
    run_cmd(ACT_WRITE, 8'h80, 1'b0, 0);
    run_cmd(ACT_WAIT, '0, 1'b0, 5);
    run_cmd(ACT_READ, '0, 1'b0, 0);

    write_regs(8'd1, 8'd1, 10'd1, 1'b0);
    run_cmd(ACT_WAIT, '0, 1'b0, 2);
    run_cmd(ACT_WRITE, 8'h01, 1'b1, 0);

    base  = issued;
    quota = (ItemTarget - issued) / 6;
    for (int p = 0; p < 6; p++) begin
      su = ($urandom_range(7) == 0) ? 8'd0 : ByteW'($urandom_range(6, 1));
      bp = ($urandom_range(7) == 0) ? 8'd0 : ByteW'($urandom_range(4, 1));
      at = ($urandom_range(5) == 0) ? 10'd0 : TickW'($urandom_range(24, 1));
      write_regs(su, bp, at, p == 2);
      // drop all idling for the last phase
      steady = (p == 5);
      while (issued < base + (p + 1) * quota) begin
        if ($urandom_range(3) != 0) begin
          run_transfer();
        end else begin
          run_cmd(ActionW'($urandom_range(7)), ByteW'($urandom), 1'($urandom), ack_hold());
        end
      end
    end

    settle();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("i2c_master_bit_sequencer_top: match");
    end else begin
      $display("i2c_master_bit_sequencer_top: mismatch");
    end
    $finish;
  end

endmodule
